// ===== sv/rac_pkg.sv =====
`timescale 1ns / 1ps

package rac_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam int ADDR_W    = 32;
    localparam int INDEX_W   = 4;
    localparam int KIND_W    = 2;
    localparam int PERM_W    = 3;
    localparam int WIDTHS_W  = 3;
    localparam int OP_W      = 3;
    localparam int SIZE_W    = 3;
    localparam int STATUS_W  = 3;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_FETCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOAD   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STORE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FETCH  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ROM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEVICE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

    localparam logic [PERM_W-1:0] PERM_READ  = 3'b001;
    localparam logic [PERM_W-1:0] PERM_WRITE = 3'b010;
    localparam logic [PERM_W-1:0] PERM_EXEC  = 3'b100;

    localparam logic [ADDR_W-1:0] MIN_REGION_LEN = 32'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PROBE,
        S_SCAN,
        S_FINAL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   length;
        logic [ADDR_W-1:0]   last;
        logic [KIND_W-1:0]   kind;
        logic [PERM_W-1:0]   perm;
        logic [WIDTHS_W-1:0] widths;
    } entry_t;

endpackage

// ===== sv/region_access_checker.sv =====
`timescale 1ns / 1ps

// channel  handshake          payload
// s_       s_valid / s_ready  s_op s_address s_access_size s_region_size
//                             s_region_kind s_region_perm s_region_widths
// m_       m_valid / m_ready  m_status m_region_index m_offset m_hit_kind
//
// clear, unused ops and early rejects go decode to out; the result loads in out
// add scans for overlap, access probes the last hit and scans on a miss: one table
// entry per cycle through the region table read port and the shared compare unit
// reset zeroes the entry count and last hit; table contents are not cleared
// a finished result waits in the output register while the next beat is taken
// the sequencer stalls before loading a result only if the previous one is unread

module region_access_checker
    import rac_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [ADDR_W-1:0]   s_address,
    input  logic [SIZE_W-1:0]   s_access_size,
    input  logic [ADDR_W-1:0]   s_region_size,
    input  logic [KIND_W-1:0]   s_region_kind,
    input  logic [PERM_W-1:0]   s_region_perm,
    input  logic [WIDTHS_W-1:0] s_region_widths,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [INDEX_W-1:0]  m_region_index,
    output logic [ADDR_W-1:0]   m_offset,
    output logic [KIND_W-1:0]   m_hit_kind
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    entry_t table_mem [MAX_ENTRIES];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] last_hit_reg, last_hit_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    // captured request
    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   rsz_reg;
    logic [ADDR_W-1:0]   a1_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [PERM_W-1:0]   perm_reg;
    logic [WIDTHS_W-1:0] widths_reg;

    // matched region
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0]   hit_off_reg, hit_off_next;
    logic [ADDR_W-1:0]   hit_len_reg, hit_len_next;
    logic [KIND_W-1:0]   hit_kind_reg, hit_kind_next;
    logic [PERM_W-1:0]   hit_perm_reg, hit_perm_next;
    logic [WIDTHS_W-1:0] hit_widths_reg, hit_widths_next;

    // pending result
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [ADDR_W-1:0]   res_off_reg, res_off_next;
    logic [KIND_W-1:0]   res_kind_reg, res_kind_next;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [ADDR_W-1:0]   m_off_reg;
    logic [KIND_W-1:0]   m_kind_reg;

    logic                accept;
    logic                out_load;
    logic                scan_more;
    logic                cmp_last;
    logic [ADDR_W-1:0]   rel_off;
    logic                holds;
    logic                overlap;
    logic [STATUS_W-1:0] fault_code;
    logic [PERM_W-1:0]   need_perm;
    logic                size_ok;
    logic                width_ok;
    logic                fits;
    logic                kind_bad;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_region_index = m_index_reg;
    assign m_offset       = m_off_reg;
    assign m_hit_kind     = m_kind_reg;

    // shared compare unit on the entry just read
    assign rel_off   = addr_reg - rd_data_reg.base;
    assign holds     = rel_off < rd_data_reg.length;
    assign overlap   = (addr_reg <= rd_data_reg.last) && (rd_data_reg.base <= a1_reg);
    assign scan_more = scan_idx_reg < count_reg;
    assign cmp_last  = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg;

    assign wr_data.base   = addr_reg;
    assign wr_data.length = rsz_reg;
    assign wr_data.last   = a1_reg;
    assign wr_data.kind   = kind_reg;
    assign wr_data.perm   = perm_reg;
    assign wr_data.widths = widths_reg;

    always_comb begin
        unique case (op_reg)
            OP_READ:  begin fault_code = ST_LOAD;  need_perm = PERM_READ;  end
            OP_WRITE: begin fault_code = ST_STORE; need_perm = PERM_WRITE; end
            default:  begin fault_code = ST_FETCH; need_perm = PERM_EXEC;  end
        endcase
    end

    always_comb begin
        size_ok  = 1'b1;
        width_ok = 1'b0;
        unique case (size_reg)
            SIZE_BYTE: width_ok = hit_widths_reg[0];
            SIZE_HALF: width_ok = hit_widths_reg[1];
            SIZE_WORD: width_ok = hit_widths_reg[2];
            default:   size_ok  = 1'b0;
        endcase
    end

    assign fits     = !(hit_off_reg > (hit_len_reg - ADDR_W'(size_reg)));
    assign kind_bad = ((op_reg == OP_WRITE) && (hit_kind_reg == KIND_ROM)) ||
                      ((op_reg == OP_FETCH) && (hit_kind_reg == KIND_DEVICE));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            last_hit_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_hit_reg <= last_hit_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_off_reg    <= hit_off_next;
        hit_len_reg    <= hit_len_next;
        hit_kind_reg   <= hit_kind_next;
        hit_perm_reg   <= hit_perm_next;
        hit_widths_reg <= hit_widths_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_off_reg    <= res_off_next;
        res_kind_reg   <= res_kind_next;
        if (accept) begin
            op_reg     <= s_op;
            addr_reg   <= s_address;
            rsz_reg    <= s_region_size;
            a1_reg     <= s_address + s_region_size - ADDR_W'(1);
            size_reg   <= (s_op == OP_FETCH) ? SIZE_HALF : s_access_size;
            kind_reg   <= s_region_kind;
            perm_reg   <= s_region_perm;
            widths_reg <= s_region_widths;
        end
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_off_reg    <= res_off_reg;
            m_kind_reg   <= res_kind_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_hit_next   = last_hit_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_off_next    = hit_off_reg;
        hit_len_next    = hit_len_reg;
        hit_kind_next   = hit_kind_reg;
        hit_perm_next   = hit_perm_reg;
        hit_widths_next = hit_widths_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_off_next    = res_off_reg;
        res_kind_next   = res_kind_reg;
        wr_en           = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                res_status_next = ST_OK;
                res_index_next  = '0;
                res_off_next    = '0;
                res_kind_next   = '0;
                state_next      = S_OUT;
                unique case (op_reg)
                    OP_CLEAR: begin
                        count_next    = '0;
                        last_hit_next = '0;
                    end
                    OP_ADD: begin
                        if (count_reg >= CNT_MAX || rsz_reg < MIN_REGION_LEN) begin
                            res_status_next = ST_REJECT;
                        end else if (count_reg == '0) begin
                            wr_en          = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                            res_index_next = INDEX_W'(count_reg);
                            res_kind_next  = kind_reg;
                        end else begin
                            // entry 0 read goes out now
                            scan_idx_next = CNT_W'(1);
                            cmp_idx_next  = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    OP_READ, OP_WRITE, OP_FETCH: begin
                        if (!size_ok || count_reg == '0) begin
                            res_status_next = fault_code;
                        end else if (CNT_W'(last_hit_reg) < count_reg) begin
                            rd_addr    = last_hit_reg;
                            state_next = S_PROBE;
                        end else begin
                            scan_idx_next = CNT_W'(1);
                            cmp_idx_next  = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_PROBE: begin
                if (holds) begin
                    hit_idx_next    = last_hit_reg;
                    hit_off_next    = rel_off;
                    hit_len_next    = rd_data_reg.length;
                    hit_kind_next   = rd_data_reg.kind;
                    hit_perm_next   = rd_data_reg.perm;
                    hit_widths_next = rd_data_reg.widths;
                    state_next      = S_FINAL;
                end else begin
                    scan_idx_next = CNT_W'(1);
                    cmp_idx_next  = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN: begin
                // read runs one entry ahead of the compare
                rd_addr       = scan_more ? scan_idx_reg[IDX_W-1:0] : '0;
                scan_idx_next = scan_idx_reg + CNT_W'(1);
                cmp_idx_next  = cmp_idx_reg + IDX_W'(1);
                if (op_reg == OP_ADD) begin
                    if (overlap) begin
                        res_status_next = ST_REJECT;
                        state_next      = S_OUT;
                    end else if (cmp_last) begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_OK;
                        res_index_next  = INDEX_W'(count_reg);
                        res_kind_next   = kind_reg;
                        state_next      = S_OUT;
                    end
                end else begin
                    if (holds) begin
                        last_hit_next   = cmp_idx_reg;
                        hit_idx_next    = cmp_idx_reg;
                        hit_off_next    = rel_off;
                        hit_len_next    = rd_data_reg.length;
                        hit_kind_next   = rd_data_reg.kind;
                        hit_perm_next   = rd_data_reg.perm;
                        hit_widths_next = rd_data_reg.widths;
                        state_next      = S_FINAL;
                    end else if (cmp_last) begin
                        res_status_next = fault_code;
                        state_next      = S_OUT;
                    end
                end
            end

            S_FINAL: begin
                state_next = S_OUT;
                if (fits && ((hit_perm_reg & need_perm) != '0) && width_ok && !kind_bad) begin
                    res_status_next = ST_OK;
                    res_index_next  = INDEX_W'(hit_idx_reg);
                    res_off_next    = hit_off_reg;
                    res_kind_next   = hit_kind_reg;
                end else begin
                    res_status_next = fault_code;
                end
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("entry count beyond table depth");

    a_last_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_hit_reg == '0) || (CNT_W'(last_hit_reg) < count_reg))
        else $error("last hit points past the filled table");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg < CNT_MAX))
        else $error("table write with no room");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == '0) || (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |->
            ((m_offset == '0) && (m_region_index == '0) && (m_hit_kind == '0)))
        else $error("fault beat carries region fields");
`endif

endmodule
